@@ hw/rtl/alpid_pkg.sv @@
`timescale 1ns / 1ps
package alpid_pkg;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;

    // fixed field widths of the ports
    localparam int KIND_W = 2;
    localparam int POS_W  = 6;
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int STAT_W = 2;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 2'd0,
        KIND_WRITE  = 2'd1,
        KIND_INSERT = 2'd2,
        KIND_DELETE = 2'd3
    } t_kind;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic                   we;
        logic [ADDR_W-1:0]      waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic                   re;
        logic [ADDR_W-1:0]      raddr;
    } t_mem_req;

endpackage

@@ hw/rtl/alpid_ram.sv @@
`timescale 1ns / 1ps
module alpid_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/alpid_ctrl.sv @@
`timescale 1ns / 1ps
module alpid_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [alpid_pkg::KIND_W-1:0]    i_kind,
    input  logic [alpid_pkg::POS_W-1:0]     i_position,
    input  logic [alpid_pkg::DATA_W-1:0]    i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [alpid_pkg::DATA_W-1:0]    o_read_value,
    output logic [alpid_pkg::LEN_W-1:0]     o_length,
    output logic [alpid_pkg::STAT_W-1:0]    o_status,
    output alpid_pkg::t_mem_req             o_mem_req,
    input  logic [alpid_pkg::VALUE_WIDTH-1:0] i_mem_rdata
);
    import alpid_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_INS,
        S_INSFIN,
        S_DEL,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [ADDR_W-1:0]      r_src, n_src;
    logic [ADDR_W-1:0]      r_pos, n_pos;
    logic [ADDR_W-1:0]      r_lim, n_lim;
    logic [VALUE_WIDTH-1:0] r_val, n_val;
    logic [VALUE_WIDTH-1:0] r_res_rd, n_res_rd;
    t_status                r_res_status, n_res_status;
    logic                   r_out_valid, n_out_valid;
    logic [DATA_W-1:0]      r_out_rd, n_out_rd;
    logic [LEN_W-1:0]       r_out_len, n_out_len;
    t_status                r_out_status, n_out_status;
    t_mem_req               mem_req;

    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       cnt_c;
    logic [ADDR_W-1:0]      pos_a;
    logic [ADDR_W-1:0]      cnt_a;
    logic                   in_range;
    logic                   is_full;
    logic                   accept;
    logic                   out_free;

    assign pos_c    = CMP_W'(i_position);
    assign cnt_c    = CMP_W'(r_count);
    assign pos_a    = pos_c[ADDR_W-1:0];
    assign cnt_a    = r_count[ADDR_W-1:0];
    assign in_range = pos_c < cnt_c;
    assign is_full  = r_count == CNT_W'(CAPACITY);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_src        = r_src;
        n_pos        = r_pos;
        n_lim        = r_lim;
        n_val        = r_val;
        n_res_rd     = r_res_rd;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_rd     = r_out_rd;
        n_out_len    = r_out_len;
        n_out_status = r_out_status;
        mem_req      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_rd     = '0;
                    n_res_status = ST_DONE;
                    n_state      = S_DONE;
                    n_val        = VALUE_WIDTH'(i_value);
                    n_pos        = pos_a;
                    case (t_kind'(i_kind))
                        KIND_READ: begin
                            if (in_range) begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pos_a;
                                n_state       = S_RDWAIT;
                            end else begin
                                n_res_status = ST_INVALID;
                            end
                        end
                        KIND_WRITE: begin
                            if (in_range) begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = pos_a;
                                mem_req.wdata = VALUE_WIDTH'(i_value);
                            end else begin
                                n_res_status = ST_INVALID;
                            end
                        end
                        KIND_INSERT: begin
                            if (is_full) begin
                                n_res_status = ST_FULL;
                            end else if (!in_range) begin
                                // append at the tail
                                mem_req.we    = 1'b1;
                                mem_req.waddr = cnt_a;
                                mem_req.wdata = VALUE_WIDTH'(i_value);
                                n_count       = r_count + CNT_W'(1);
                            end else begin
                                // shift up from the tail toward the position
                                mem_req.re    = 1'b1;
                                mem_req.raddr = cnt_a - ADDR_W'(1);
                                n_src         = cnt_a - ADDR_W'(1);
                                n_count       = r_count + CNT_W'(1);
                                n_state       = S_INS;
                            end
                        end
                        KIND_DELETE: begin
                            if (!in_range) begin
                                n_res_status = ST_INVALID;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                                if ((pos_c + CMP_W'(1)) < cnt_c) begin
                                    mem_req.re    = 1'b1;
                                    mem_req.raddr = pos_a + ADDR_W'(1);
                                    n_src         = pos_a + ADDR_W'(1);
                                    n_lim         = cnt_a - ADDR_W'(1);
                                    n_state       = S_DEL;
                                end
                            end
                        end
                        default: begin
                            n_res_status = ST_INVALID;
                        end
                    endcase
                end
            end
            S_RDWAIT: begin
                n_res_rd = i_mem_rdata;
                n_state  = S_DONE;
            end
            S_INS: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_src + ADDR_W'(1);
                mem_req.wdata = i_mem_rdata;
                if (r_src == r_pos) begin
                    n_state = S_INSFIN;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_src - ADDR_W'(1);
                    n_src         = r_src - ADDR_W'(1);
                end
            end
            S_INSFIN: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_pos;
                mem_req.wdata = r_val;
                n_state       = S_DONE;
            end
            S_DEL: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_src - ADDR_W'(1);
                mem_req.wdata = i_mem_rdata;
                if (r_src == r_lim) begin
                    n_state = S_DONE;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_src + ADDR_W'(1);
                    n_src         = r_src + ADDR_W'(1);
                end
            end
            S_DONE: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_rd     = DATA_W'(r_res_rd);
                    n_out_len    = LEN_W'(r_count);
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_src        <= '0;
            r_pos        <= '0;
            r_lim        <= '0;
            r_val        <= '0;
            r_res_rd     <= '0;
            r_res_status <= ST_DONE;
            r_out_valid  <= 1'b0;
            r_out_rd     <= '0;
            r_out_len    <= '0;
            r_out_status <= ST_DONE;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_src        <= n_src;
            r_pos        <= n_pos;
            r_lim        <= n_lim;
            r_val        <= n_val;
            r_res_rd     <= n_res_rd;
            r_res_status <= n_res_status;
            r_out_valid  <= n_out_valid;
            r_out_rd     <= n_out_rd;
            r_out_len    <= n_out_len;
            r_out_status <= n_out_status;
        end
    end

    assign o_in_ready   = r_state == S_IDLE;
    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_length     = r_out_len;
    assign o_status     = r_out_status;
    assign o_mem_req    = mem_req;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("list length exceeds capacity");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("read and write hit the same entry in one cycle");

    a_ins_src_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> (r_src >= r_pos))
        else $error("insert shift ran below the insert position");

    a_del_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEL) |-> (CNT_W'(r_lim) == r_count) && (r_src <= r_lim))
        else $error("delete shift limit out of step with the length");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted transaction left the controller idle");

endmodule

@@ hw/rtl/array_list_positional_insert_delete.sv @@
`timescale 1ns / 1ps
// Ordered list of up to CAPACITY entries kept in one memory with one write and
// one registered read port. A transaction reads, writes, inserts or deletes at a
// position; one result comes back per transaction. Refused operations, writes and
// appends go straight to the result state; a read first waits in a state for the
// memory data; an insert inside the list shifts the entries behind the position
// up and then writes the new value; a delete shifts the entries behind the
// position down, with no shift when the last entry is removed. The shift of
// insert and delete moves one entry per cycle through the memory, read one cycle
// and written back the next, so it takes longer the more entries lie behind the
// position. One transaction is in work at a time; a finished result may wait in
// the output register while the next transaction is accepted. No clearing pass
// after reset: entries at or past the length are never read.
module array_list_positional_insert_delete (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [alpid_pkg::KIND_W-1:0] i_kind,
    input  logic [alpid_pkg::POS_W-1:0]  i_position,
    input  logic [alpid_pkg::DATA_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [alpid_pkg::DATA_W-1:0] o_read_value,
    output logic [alpid_pkg::LEN_W-1:0]  o_length,
    output logic [alpid_pkg::STAT_W-1:0] o_status
);
    import alpid_pkg::*;

    t_mem_req               mem_req;
    logic [VALUE_WIDTH-1:0] mem_rdata;

    alpid_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_length     (o_length),
        .o_status     (o_status),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    alpid_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (VALUE_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

endmodule
